/* hw/rtl/bhpq_pkg.sv */
`default_nettype none

package bhpq_pkg;

  // default sizes
  localparam int CapacityDef     = 64;
  localparam int KeyWidthDef     = 32;
  localparam int PayloadWidthDef = 16;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t StOk    = 2'd0;
  localparam status_t StEmpty = 2'd1;
  localparam status_t StFull  = 2'd2;

  // action codes of an input word
  localparam logic ActPush = 1'b0;
  localparam logic ActPop  = 1'b1;

  // order mode codes
  localparam logic ModeMaxFirst = 1'b0;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OpNone,
    OpPush,
    OpPop,
    OpFull,
    OpEmpty,
    OpUpRoot,
    OpRdUp,
    OpUp,
    OpLoadLast,
    OpRdDn,
    OpDn
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;      // no room for a push
    logic empty;     // nothing to pop
    logic pop_last;  // pop takes the only entry
    logic at_root;   // hole sits at the root
    logic up_move;   // new entry rises above its parent
    logic dn_move;   // a child rises into the hole
  } dp_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/bhpq_dp.sv */
`default_nettype none

module bhpq_dp #(
  parameter int CAPACITY      = bhpq_pkg::CapacityDef,
  parameter int KEY_WIDTH     = bhpq_pkg::KeyWidthDef,
  parameter int PAYLOAD_WIDTH = bhpq_pkg::PayloadWidthDef,
  parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_wdata_i,
  input  wire logic [KEY_WIDTH-1:0]     key_i,
  input  wire logic [PAYLOAD_WIDTH-1:0] payload_i,
  input  wire bhpq_pkg::dp_cmd_t        cmd_i,
  output      bhpq_pkg::dp_stat_t       stat_o,
  output      bhpq_pkg::status_t        status_o,
  output      logic [KEY_WIDTH-1:0]     popped_key_o,
  output      logic [PAYLOAD_WIDTH-1:0] popped_payload_o,
  output      logic [KEY_WIDTH-1:0]     top_key_o,
  output      logic [PAYLOAD_WIDTH-1:0] top_payload_o,
  output      logic [CNT_W-1:0]         entry_count_o,
  output      logic                     is_empty_o
);
  import bhpq_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int ENT_W = KEY_WIDTH + PAYLOAD_WIDTH;
  localparam int CW    = IDX_W + 2;

  function automatic logic ahead(input logic [KEY_WIDTH-1:0] a,
                                 input logic [KEY_WIDTH-1:0] b,
                                 input logic                 m);
    return (m == ModeMaxFirst) ? (a > b) : (a < b);
  endfunction

  logic [ENT_W-1:0] mem_q [CAPACITY];
  logic [ENT_W-1:0] rd_a_q, rd_b_q;

  logic             mode_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [ENT_W-1:0] mov_q, mov_d;
  logic [ENT_W-1:0] top_q, top_d;
  logic [ENT_W-1:0] pop_q, pop_d;
  status_t          st_q, st_d;

  logic             we;
  logic [IDX_W-1:0] wa;
  logic [ENT_W-1:0] wd;
  logic [IDX_W-1:0] ra_a, ra_b;

  logic [CNT_W-1:0] cnt_m1;
  logic [IDX_W-1:0] pos_m1, parent;
  logic [CW-1:0]    lc, rc, cnt_x;
  logic             l_in, r_in, pick_r, up_move, dn_move;
  logic [ENT_W-1:0] pick;
  logic [IDX_W-1:0] pick_idx;
  logic             empty;

  // tree geometry around the hole
  assign cnt_m1 = cnt_q - CNT_W'(1);
  assign pos_m1 = pos_q - IDX_W'(1);
  assign parent = pos_m1 >> 1;
  assign lc     = {1'b0, pos_q, 1'b1};
  assign rc     = lc + CW'(1);
  assign cnt_x  = CW'(cnt_q);
  assign l_in   = lc < cnt_x;
  assign r_in   = rc < cnt_x;

  // compares against the registered read words
  assign pick_r   = r_in && ahead(rd_b_q[ENT_W-1 -: KEY_WIDTH],
                                  rd_a_q[ENT_W-1 -: KEY_WIDTH], mode_q);
  assign pick     = pick_r ? rd_b_q : rd_a_q;
  assign pick_idx = pick_r ? rc[IDX_W-1:0] : lc[IDX_W-1:0];
  assign dn_move  = l_in && ahead(pick[ENT_W-1 -: KEY_WIDTH],
                                  mov_q[ENT_W-1 -: KEY_WIDTH], mode_q);
  assign up_move  = ahead(mov_q[ENT_W-1 -: KEY_WIDTH],
                          rd_a_q[ENT_W-1 -: KEY_WIDTH], mode_q);
  assign empty    = cnt_q == '0;

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    mov_d = mov_q;
    pop_d = pop_q;
    st_d  = st_q;
    we    = 1'b0;
    wa    = pos_q;
    wd    = mov_q;
    ra_a  = lc[IDX_W-1:0];
    ra_b  = rc[IDX_W-1:0];
    case (cmd_i.op)
      OpPush: begin
        mov_d = {key_i, payload_i};
        pos_d = cnt_q[IDX_W-1:0];
        cnt_d = cnt_q + CNT_W'(1);
        pop_d = '0;
        st_d  = StOk;
      end
      OpPop: begin
        pop_d = top_q;
        cnt_d = cnt_m1;
        pos_d = '0;
        st_d  = StOk;
        ra_a  = cnt_m1[IDX_W-1:0];
      end
      OpFull: begin
        pop_d = '0;
        st_d  = StFull;
      end
      OpEmpty: begin
        pop_d = '0;
        st_d  = StEmpty;
      end
      OpUpRoot: begin
        we = 1'b1;
      end
      OpRdUp: begin
        ra_a = parent;
      end
      OpUp: begin
        we = 1'b1;
        if (up_move) begin
          wd    = rd_a_q;
          pos_d = parent;
        end
      end
      OpLoadLast: begin
        // hole is at the root, children reads go out now
        mov_d = rd_a_q;
      end
      OpDn: begin
        we = 1'b1;
        if (dn_move) begin
          wd    = pick;
          pos_d = pick_idx;
        end
      end
      default: begin
      end
    endcase
    top_d = (we && wa == '0) ? wd : top_q;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_a_q <= mem_q[ra_a];
    rd_b_q <= mem_q[ra_b];
    pos_q  <= pos_d;
    mov_q  <= mov_d;
    top_q  <= top_d;
    pop_q  <= pop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeMaxFirst;
      cnt_q  <= '0;
      st_q   <= StOk;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

  assign stat_o.full     = cnt_q == CNT_W'(CAPACITY);
  assign stat_o.empty    = empty;
  assign stat_o.pop_last = cnt_q == CNT_W'(1);
  assign stat_o.at_root  = pos_q == '0;
  assign stat_o.up_move  = up_move;
  assign stat_o.dn_move  = dn_move;

  assign status_o         = st_q;
  assign popped_key_o     = pop_q[ENT_W-1 -: KEY_WIDTH];
  assign popped_payload_o = pop_q[PAYLOAD_WIDTH-1:0];
  assign top_key_o        = empty ? '0 : top_q[ENT_W-1 -: KEY_WIDTH];
  assign top_payload_o    = empty ? '0 : top_q[PAYLOAD_WIDTH-1:0];
  assign entry_count_o    = cnt_q;
  assign is_empty_o       = empty;

endmodule

`default_nettype wire

/* hw/rtl/bhpq_ctrl.sv */
`default_nettype none

module bhpq_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               action_i,
  input  wire bhpq_pkg::dp_stat_t stat_i,
  output      bhpq_pkg::dp_cmd_t  cmd_o,
  output      logic               busy_o,
  output      logic               done_o
);
  import bhpq_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SUpRd,
    SUp,
    SLoad,
    SDnRd,
    SDn
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   busy_q;
  dp_op_e op;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    op      = OpNone;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          if (action_i == ActPop) begin
            if (stat_i.empty) begin
              op     = OpEmpty;
              done_d = 1'b1;
            end else begin
              op = OpPop;
              if (stat_i.pop_last) begin
                done_d = 1'b1;
              end else begin
                state_d = SLoad;
              end
            end
          end else begin
            if (stat_i.full) begin
              op     = OpFull;
              done_d = 1'b1;
            end else begin
              op      = OpPush;
              state_d = SUpRd;
            end
          end
        end
      end
      SUpRd: begin
        if (stat_i.at_root) begin
          op      = OpUpRoot;
          state_d = SIdle;
          done_d  = 1'b1;
        end else begin
          op      = OpRdUp;
          state_d = SUp;
        end
      end
      SUp: begin
        op = OpUp;
        if (stat_i.up_move) begin
          state_d = SUpRd;
        end else begin
          state_d = SIdle;
          done_d  = 1'b1;
        end
      end
      SLoad: begin
        op      = OpLoadLast;
        state_d = SDn;
      end
      SDnRd: begin
        op      = OpRdDn;
        state_d = SDn;
      end
      SDn: begin
        op = OpDn;
        if (stat_i.dn_move) begin
          state_d = SDnRd;
        end else begin
          state_d = SIdle;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      busy_q  <= state_d != SIdle;
    end
  end

  assign cmd_o.op = op;
  assign busy_o   = busy_q;
  assign done_o   = done_q;

endmodule

`default_nettype wire

/* hw/rtl/binary_heap_priority_queue.sv */
`default_nettype none

// channel    direction  signals
// command    in         start_i, busy_o, action_i, key_i, payload_i
// result     out        done_o, status_o, popped_key_o, popped_payload_o,
//                       top_key_o, top_payload_o, entry_count_o, is_empty_o
// config     in         cfg_we_i, cfg_wdata_i (order mode)
//
// a word is taken at a clock edge with start_i high and busy_o low
// push: puts a hole at the end, then climbs a level at a time until the new entry stops or reaches the root
// pop: takes the root, loads the last entry, then sinks it a level at a time while a child rises into the hole
// refused words and a pop of the last entry walk no levels; a level is a read, then a write
// done_o pulses one cycle with the result; the receiver cannot stall it
// reset clears the entry count and order mode, memory contents are not reset

module binary_heap_priority_queue #(
  parameter int CAPACITY      = bhpq_pkg::CapacityDef,
  parameter int KEY_WIDTH     = bhpq_pkg::KeyWidthDef,
  parameter int PAYLOAD_WIDTH = bhpq_pkg::PayloadWidthDef,
  parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_wdata_i,
  input  wire logic                     start_i,
  output      logic                     busy_o,
  input  wire logic                     action_i,
  input  wire logic [KEY_WIDTH-1:0]     key_i,
  input  wire logic [PAYLOAD_WIDTH-1:0] payload_i,
  output      logic                     done_o,
  output      bhpq_pkg::status_t        status_o,
  output      logic [KEY_WIDTH-1:0]     popped_key_o,
  output      logic [PAYLOAD_WIDTH-1:0] popped_payload_o,
  output      logic [KEY_WIDTH-1:0]     top_key_o,
  output      logic [PAYLOAD_WIDTH-1:0] top_payload_o,
  output      logic [CNT_W-1:0]         entry_count_o,
  output      logic                     is_empty_o
);
  import bhpq_pkg::*;

  // controller to datapath operations and datapath flags back
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: one word at a time, walks the tree a level at a time, a read state then a write state
  bhpq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  // heap memory, hole register, root copy and result registers
  bhpq_dp #(
    .CAPACITY      (CAPACITY),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .CNT_W         (CNT_W)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .key_i            (key_i),
    .payload_i        (payload_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .status_o         (status_o),
    .popped_key_o     (popped_key_o),
    .popped_payload_o (popped_payload_o),
    .top_key_o        (top_key_o),
    .top_payload_o    (top_payload_o),
    .entry_count_o    (entry_count_o),
    .is_empty_o       (is_empty_o)
  );

endmodule

`default_nettype wire
